[design/i2c_rrs_pkg.sv]
// ----------------------------------------------------------------------------
// I2C register-read sequencer package
// Shared codes for bus actions, commands and status, and the stream layouts.
// ----------------------------------------------------------------------------
package i2c_rrs_pkg;

    localparam int S_TDATA_W = 32;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 32;

    typedef enum logic [1:0] {
        CMD_NONE    = 2'd0,
        CMD_READ    = 2'd1,
        CMD_RELEASE = 2'd2,
        CMD_UNUSED  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE     = 2'd0,
        ST_READING  = 2'd1,
        ST_COMPLETE = 2'd2
    } status_t;

    localparam logic [3:0] ACT_NONE         = 4'd0;
    localparam logic [3:0] ACT_START_SEND   = 4'd1;
    localparam logic [3:0] ACT_SEND         = 4'd2;
    localparam logic [3:0] ACT_RESTART_SEND = 4'd3;
    localparam logic [3:0] ACT_RX_MODE      = 4'd4;
    localparam logic [3:0] ACT_ACK_DUMMY    = 4'd5;
    localparam logic [3:0] ACT_NACK_DUMMY   = 4'd6;
    localparam logic [3:0] ACT_CLEAR_FLAG   = 4'd7;
    localparam logic [3:0] ACT_STOP_READ    = 4'd8;
    localparam logic [3:0] ACT_READ         = 4'd9;

    localparam logic [7:0] READ_BIT = 8'h01;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] dev_addr;
        logic [7:0] reg_addr;
        logic [4:0] byte_count;
        logic       bus_flag;
        logic [7:0] bus_data;
    } req_t;

    typedef struct packed {
        logic [3:0] bus_action;
        logic [7:0] tx_byte;
        logic       rx_valid;
        logic [7:0] rx_byte;
        logic [3:0] rx_index;
        logic [1:0] status_code;
    } rsp_t;

endpackage

[design/i2c_rrs_seq.sv]
// ----------------------------------------------------------------------------
// I2C register-read sequencer step
// Holds the sequencer state and computes one step's result; the state
// advances when the top level moves a transaction into its result register.
// ----------------------------------------------------------------------------
module i2c_rrs_seq
    import i2c_rrs_pkg::*;
#(
    parameter int MAX_BYTES = 16
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic step,
    input  req_t req,
    output rsp_t rsp
);

    // byte_count is 5 bits wide, so saturation only bites below 31
    localparam int CNT_LIMIT = (MAX_BYTES > 31) ? 31 : MAX_BYTES;
    localparam logic [4:0] CNT_MAX = 5'(CNT_LIMIT);

    typedef enum logic [3:0] {
        P_WAIT_REQ   = 4'd0,
        P_WAIT_ADDR  = 4'd1,
        P_SEND_REG   = 4'd2,
        P_WAIT_REG   = 4'd3,
        P_RESTART    = 4'd4,
        P_WAIT_RADDR = 4'd5,
        P_RX_MODE    = 4'd6,
        P_BYTE_SETUP = 4'd7,
        P_WAIT_BYTE  = 4'd8,
        P_TAKE_BYTE  = 4'd9,
        P_FINISH     = 4'd10
    } phase_t;

    phase_t     phase_reg, phase_next;
    status_t    status_reg, status_next;
    logic [7:0] dev_reg, dev_next;
    logic [7:0] regaddr_reg, regaddr_next;
    logic [4:0] count_reg, count_next;
    logic [4:0] done_reg, done_next;
    logic       last_reg, last_next;

    always_comb
    begin
        phase_next   = phase_reg;
        status_next  = status_reg;
        dev_next     = dev_reg;
        regaddr_next = regaddr_reg;
        count_next   = count_reg;
        done_next    = done_reg;
        last_next    = last_reg;
        rsp          = '0;

        // release acts ahead of the sequencer step
        if (req.command == CMD_RELEASE && status_reg == ST_COMPLETE)
            status_next = ST_IDLE;

        case (phase_reg)
            P_WAIT_REQ:
            begin
                if (status_next == ST_IDLE && req.command == CMD_READ)
                begin
                    status_next    = ST_READING;
                    count_next     = (req.byte_count > CNT_MAX) ? CNT_MAX : req.byte_count;
                    regaddr_next   = req.reg_addr;
                    dev_next       = req.dev_addr;
                    rsp.bus_action = ACT_START_SEND;
                    rsp.tx_byte    = req.dev_addr;
                    phase_next     = P_WAIT_ADDR;
                end
            end
            P_WAIT_ADDR:
            begin
                if (req.bus_flag)
                begin
                    rsp.bus_action = ACT_CLEAR_FLAG;
                    phase_next     = P_SEND_REG;
                end
            end
            P_SEND_REG:
            begin
                rsp.bus_action = ACT_SEND;
                rsp.tx_byte    = regaddr_reg;
                phase_next     = P_WAIT_REG;
            end
            P_WAIT_REG:
            begin
                if (req.bus_flag)
                begin
                    rsp.bus_action = ACT_CLEAR_FLAG;
                    phase_next     = P_RESTART;
                end
            end
            P_RESTART:
            begin
                rsp.bus_action = ACT_RESTART_SEND;
                rsp.tx_byte    = dev_reg | READ_BIT;
                phase_next     = P_WAIT_RADDR;
            end
            P_WAIT_RADDR:
            begin
                if (req.bus_flag)
                begin
                    rsp.bus_action = ACT_CLEAR_FLAG;
                    phase_next     = P_RX_MODE;
                end
            end
            P_RX_MODE:
            begin
                rsp.bus_action = ACT_RX_MODE;
                phase_next     = P_BYTE_SETUP;
            end
            P_BYTE_SETUP:
            begin
                if (done_reg < count_reg)
                begin
                    last_next      = (done_reg + 5'd1 == count_reg);
                    rsp.bus_action = last_next ? ACT_NACK_DUMMY : ACT_ACK_DUMMY;
                    phase_next     = P_WAIT_BYTE;
                end
                else
                begin
                    phase_next = P_FINISH;
                end
            end
            P_WAIT_BYTE:
            begin
                if (req.bus_flag)
                begin
                    rsp.bus_action = ACT_CLEAR_FLAG;
                    phase_next     = P_TAKE_BYTE;
                end
            end
            P_TAKE_BYTE:
            begin
                rsp.bus_action = last_reg ? ACT_STOP_READ : ACT_READ;
                rsp.rx_valid   = 1'b1;
                rsp.rx_byte    = req.bus_data;
                rsp.rx_index   = done_reg[3:0];
                done_next      = done_reg + 5'd1;
                phase_next     = P_BYTE_SETUP;
            end
            P_FINISH:
            begin
                status_next = ST_COMPLETE;
                done_next   = '0;
                phase_next  = P_WAIT_REQ;
            end
            default:
            begin
                phase_next  = P_WAIT_REQ;
                status_next = ST_IDLE;
            end
        endcase

        rsp.status_code = status_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= P_WAIT_REQ;
            status_reg  <= ST_IDLE;
            dev_reg     <= '0;
            regaddr_reg <= '0;
            count_reg   <= '0;
            done_reg    <= '0;
            last_reg    <= 1'b0;
        end
        else if (step)
        begin
            phase_reg   <= phase_next;
            status_reg  <= status_next;
            dev_reg     <= dev_next;
            regaddr_reg <= regaddr_next;
            count_reg   <= count_next;
            done_reg    <= done_next;
            last_reg    <= last_next;
        end
    end

endmodule

[design/i2c_register_read_sequencer_core.sv]
// ----------------------------------------------------------------------------
// I2C register-read sequencer core
// Steps a byte-level I2C controller through a register read, one step per
// input transaction.
// ----------------------------------------------------------------------------
// Usage:
//   Each slave-side transaction is one scheduler tick: a command in s_tuser
//   plus the request fields and the controller's flag and data byte in
//   s_tdata. Each tick yields exactly one master-side transaction carrying
//   the bus action to perform, the byte to send, an optional received byte
//   with its index, and the status after the step.
//   Data passes through an input register, then a result register, with the
//   step logic between them. Throughput: one transaction per cycle while
//   m_tready stays high; the sequencer state updates in the same cycle the
//   result register loads.
//   When m_tready is low the result holds, the input register still takes
//   one more transaction, then s_tready drops until the result is taken.
//   Reset clears both registers' valid flags and returns the sequencer to
//   idle, waiting for a read request.
// ----------------------------------------------------------------------------
module i2c_register_read_sequencer_core
    import i2c_rrs_pkg::*;
#(
    parameter int MAX_BYTES = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // dev_addr[7:0], reg_addr[15:8], byte_count[20:16], bus_flag[21],
    // bus_data[29:22], zero pad [31:30]
    input  logic [S_TDATA_W-1:0] s_tdata,
    // command[1:0]
    input  logic [S_TUSER_W-1:0] s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // bus_action[3:0], tx_byte[11:4], rx_valid[12], rx_byte[20:13],
    // rx_index[24:21], status_code[26:25], zero pad [31:27]
    output logic [M_TDATA_W-1:0] m_tdata
);

    logic in_valid_reg;
    req_t in_data_reg;
    logic out_valid_reg;
    rsp_t out_data_reg;
    rsp_t rsp;
    logic step;

    assign step     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || step;

    i2c_rrs_seq #(
        .MAX_BYTES(MAX_BYTES)
    ) u_seq (
        .clk  (clk),
        .rst_n(rst_n),
        .step (step),
        .req  (in_data_reg),
        .rsp  (rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (step)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_data_reg.command    <= s_tuser[1:0];
            in_data_reg.dev_addr   <= s_tdata[7:0];
            in_data_reg.reg_addr   <= s_tdata[15:8];
            in_data_reg.byte_count <= s_tdata[20:16];
            in_data_reg.bus_flag   <= s_tdata[21];
            in_data_reg.bus_data   <= s_tdata[29:22];
        end
        if (step)
            out_data_reg <= rsp;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0,
                       out_data_reg.status_code,
                       out_data_reg.rx_index,
                       out_data_reg.rx_byte,
                       out_data_reg.rx_valid,
                       out_data_reg.tx_byte,
                       out_data_reg.bus_action};

endmodule

[design/i2c_rrs_checker.sv]
// ----------------------------------------------------------------------------
// I2C register-read sequencer checker
// Port-level checks on result transactions, bound to the core.
// ----------------------------------------------------------------------------
module i2c_rrs_checker
    import i2c_rrs_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    logic [3:0] act;
    assign act = m_tdata[3:0];

    // a received byte goes out only with a read or stop+read action
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[12] == (act == ACT_STOP_READ || act == ACT_READ)))
        else $error("rx_valid does not match read action");

    // send byte only on the three send actions
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !(act == ACT_START_SEND || act == ACT_SEND ||
                       act == ACT_RESTART_SEND)) |-> (m_tdata[11:4] == 8'd0))
        else $error("tx_byte set outside send action");

    // a byte is received only while a read is in progress
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[12]) |-> (m_tdata[26:25] == ST_READING))
        else $error("byte delivered outside reading status");

    // result holds while stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result changed while stalled");

endmodule

bind i2c_register_read_sequencer_core i2c_rrs_checker u_i2c_rrs_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
);

[sim/testbench.sv]
// ----------------------------------------------------------------------------
// I2C register-read sequencer testbench
// Feeds scheduler ticks (read requests, flag waits, releases, noise) through
// the slave stream under several idle/stall mixes, models the sequencer step
// by step and checks every master-side transaction field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;

    import i2c_rrs_pkg::*;

    localparam int MAX_BYTES      = 16;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TICKS_PER_MIX  = 475;

    typedef enum logic [3:0] {
        PH_WAIT_REQ    = 4'd0,
        PH_WAIT_ADDR   = 4'd1,
        PH_SEND_REG    = 4'd2,
        PH_WAIT_REG    = 4'd3,
        PH_RESTART     = 4'd4,
        PH_WAIT_RADDR  = 4'd5,
        PH_RX_MODE     = 4'd6,
        PH_BYTE_SETUP  = 4'd7,
        PH_WAIT_BYTE   = 4'd8,
        PH_TAKE_BYTE   = 4'd9,
        PH_FINISH      = 4'd10
    } seq_phase_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [S_TUSER_W-1:0] s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    // model state
    seq_phase_t seq_phase = PH_WAIT_REQ;
    status_t    seq_status = ST_IDLE;
    logic [7:0] held_dev_addr = '0;
    logic [7:0] held_reg_addr = '0;
    logic [4:0] held_count = '0;
    logic [4:0] bytes_taken = '0;
    logic       on_last_byte = 1'b0;

    req_t pending_ticks[$];
    rsp_t expected_steps[$];
    req_t active_tick;

    int send_idle_pct = 0;
    int ready_stall_pct = 0;
    int mismatch_count = 0;
    int idle_cycles = 0;
    int ticks_queued = 0;

    i2c_register_read_sequencer_core #(
        .MAX_BYTES (MAX_BYTES)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // One sequencer step for one accepted tick
    function automatic rsp_t advance_sequencer(input req_t t);
        rsp_t r;
        r = '0;
        if (t.command == CMD_RELEASE && seq_status == ST_COMPLETE)
            seq_status = ST_IDLE;
        case (seq_phase)
            PH_WAIT_REQ:
                if (seq_status == ST_IDLE && t.command == CMD_READ)
                begin
                    seq_status    = ST_READING;
                    held_count    = (t.byte_count > MAX_BYTES) ? 5'(MAX_BYTES) : t.byte_count;
                    held_reg_addr = t.reg_addr;
                    held_dev_addr = t.dev_addr;
                    r.bus_action  = ACT_START_SEND;
                    r.tx_byte     = t.dev_addr;
                    seq_phase     = PH_WAIT_ADDR;
                end
            PH_WAIT_ADDR:
                if (t.bus_flag)
                begin
                    r.bus_action = ACT_CLEAR_FLAG;
                    seq_phase    = PH_SEND_REG;
                end
            PH_SEND_REG:
            begin
                r.bus_action = ACT_SEND;
                r.tx_byte    = held_reg_addr;
                seq_phase    = PH_WAIT_REG;
            end
            PH_WAIT_REG:
                if (t.bus_flag)
                begin
                    r.bus_action = ACT_CLEAR_FLAG;
                    seq_phase    = PH_RESTART;
                end
            PH_RESTART:
            begin
                r.bus_action = ACT_RESTART_SEND;
                r.tx_byte    = held_dev_addr | READ_BIT;
                seq_phase    = PH_WAIT_RADDR;
            end
            PH_WAIT_RADDR:
                if (t.bus_flag)
                begin
                    r.bus_action = ACT_CLEAR_FLAG;
                    seq_phase    = PH_RX_MODE;
                end
            PH_RX_MODE:
            begin
                r.bus_action = ACT_RX_MODE;
                seq_phase    = PH_BYTE_SETUP;
            end
            PH_BYTE_SETUP:
                if (bytes_taken < held_count)
                begin
                    on_last_byte = (bytes_taken + 5'd1 == held_count);
                    r.bus_action = on_last_byte ? ACT_NACK_DUMMY : ACT_ACK_DUMMY;
                    seq_phase    = PH_WAIT_BYTE;
                end
                else
                    seq_phase = PH_FINISH;
            PH_WAIT_BYTE:
                if (t.bus_flag)
                begin
                    r.bus_action = ACT_CLEAR_FLAG;
                    seq_phase    = PH_TAKE_BYTE;
                end
            PH_TAKE_BYTE:
            begin
                r.bus_action = on_last_byte ? ACT_STOP_READ : ACT_READ;
                r.rx_valid   = 1'b1;
                r.rx_byte    = t.bus_data;
                r.rx_index   = bytes_taken[3:0];
                bytes_taken  = bytes_taken + 5'd1;
                seq_phase    = PH_BYTE_SETUP;
            end
            PH_FINISH:
            begin
                seq_status  = ST_COMPLETE;
                bytes_taken = '0;
                seq_phase   = PH_WAIT_REQ;
            end
            default:
            begin
                seq_phase  = PH_WAIT_REQ;
                seq_status = ST_IDLE;
            end
        endcase
        r.status_code = seq_status;
        return r;
    endfunction

    function automatic req_t random_tick(input cmd_t cmd);
        req_t t;
        t.command    = cmd;
        t.dev_addr   = 8'($urandom);
        t.reg_addr   = 8'($urandom);
        t.byte_count = 5'($urandom);
        t.bus_flag   = 1'($urandom);
        t.bus_data   = 8'($urandom);
        return t;
    endfunction

    function automatic cmd_t noisy_cmd(input int noise_pct);
        if ($urandom_range(99) < noise_pct)
            return cmd_t'($urandom_range(3));
        return CMD_NONE;
    endfunction

    task automatic push_tick(input req_t t);
        pending_ticks.push_back(t);
        ticks_queued++;
    endtask

    // Request, steps for the read, then (with_release) releases; enough to finish even with flag-low ticks
    task automatic queue_read(input logic [7:0] dev, input logic [7:0] reg_a,
                              input logic [4:0] cnt, input int low_pct,
                              input int noise_pct, input bit with_release);
        req_t t;
        int   n;
        int   lows;
        n = (cnt > MAX_BYTES) ? MAX_BYTES : int'(cnt);
        lows = 0;
        t = random_tick(CMD_READ);
        t.dev_addr   = dev;
        t.reg_addr   = reg_a;
        t.byte_count = cnt;
        push_tick(t);
        repeat (8 + 3 * n)
        begin
            t = random_tick(noisy_cmd(noise_pct));
            t.bus_flag = ($urandom_range(99) >= low_pct);
            if (!t.bus_flag)
                lows++;
            push_tick(t);
        end
        if (with_release)
            repeat (lows + 2)
            begin
                t = random_tick(CMD_RELEASE);
                t.bus_flag = 1'b1;
                push_tick(t);
            end
    endtask

    task automatic random_read;
        logic [4:0] cnt;
        int         pick;
        pick = $urandom_range(99);
        if (pick < 60)
            cnt = 5'($urandom_range(3));
        else if (pick < 90)
            cnt = 5'($urandom_range(16, 4));
        else
            cnt = 5'($urandom_range(31, 17));
        queue_read(8'($urandom), 8'($urandom), cnt, $urandom_range(50),
                   $urandom_range(15), $urandom_range(99) >= 8);
        // occasional stray ticks between reads
        if ($urandom_range(99) < 15)
            repeat ($urandom_range(4, 1))
                push_tick(random_tick(cmd_t'($urandom_range(3))));
    endtask

    // Poll on the falling edge; full_drain also waits for every result
    task automatic drain(input bit full_drain);
        @(negedge clk);
        while (pending_ticks.size() != 0 || s_tvalid ||
               (full_drain && expected_steps.size() != 0))
            @(negedge clk);
    endtask

    task automatic check_field(input string name, input int exp_val, input int act_val);
        if (exp_val != act_val)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_val, act_val);
            mismatch_count++;
        end
    endtask

    // driver
    always @(posedge clk)
    begin
        if (!rst_n)
            s_tvalid <= 1'b0;
        else
        begin
            if (s_tvalid && s_tready)
                expected_steps.push_back(advance_sequencer(active_tick));
            if (!s_tvalid || s_tready)
            begin
                if (pending_ticks.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    active_tick = pending_ticks.pop_front();
                    s_tdata  <= {2'b00, active_tick.bus_data, active_tick.bus_flag,
                                 active_tick.byte_count, active_tick.reg_addr,
                                 active_tick.dev_addr};
                    s_tuser  <= active_tick.command;
                    s_tvalid <= 1'b1;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        rsp_t exp_step;
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_steps.size() == 0)
                begin
                    $error("unexpected result transaction 0x%0h", m_tdata);
                    mismatch_count++;
                end
                else
                begin
                    exp_step = expected_steps.pop_front();
                    check_field("bus_action", exp_step.bus_action, m_tdata[3:0]);
                    check_field("tx_byte", exp_step.tx_byte, m_tdata[11:4]);
                    check_field("rx_valid", exp_step.rx_valid, m_tdata[12]);
                    check_field("rx_byte", exp_step.rx_byte, m_tdata[20:13]);
                    check_field("rx_index", exp_step.rx_index, m_tdata[24:21]);
                    check_field("status_code", exp_step.status_code, m_tdata[26:25]);
                    check_field("pad", 0, m_tdata[31:27]);
                end
            end
            m_tready <= ($urandom_range(99) >= ready_stall_pct);
        end
    end

    // watchdog: cycles without any transaction
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        req_t t;
        int   mix;
        int   mix_start;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed: release and unused command while idle, zero-count read,
        // short read with NACK/stop on the last byte and busy-time noise
        t = random_tick(CMD_RELEASE);
        push_tick(t);
        t = random_tick(CMD_UNUSED);
        push_tick(t);
        queue_read(8'h00, 8'hFF, 5'd0, 0, 0, 1'b1);
        queue_read(8'hFF, 8'h00, 5'd2, 30, 40, 1'b1);

        // sender holds off until every result is back
        drain(1'b1);

        for (mix = 0; mix < 4; mix++)
        begin
            case (mix)
                0: begin send_idle_pct = 0;  ready_stall_pct = 0;  end
                1: begin send_idle_pct = 72; ready_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  ready_stall_pct = 72; end
                default: begin send_idle_pct = 19; ready_stall_pct = 19; end
            endcase
            mix_start = ticks_queued;
            while (ticks_queued - mix_start < TICKS_PER_MIX)
                random_read();
            drain(1'b0);
        end

        drain(1'b1);
        repeat (10) @(posedge clk);
        if (expected_steps.size() != 0)
        begin
            $error("%0d result transactions never arrived", expected_steps.size());
            mismatch_count++;
        end
        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
